FILE: hdl/fcl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fcl_pkg
// Types, constants and helper functions shared by the configuration load
// sequencer files.
// ============================================================================
package fcl_pkg;

    // Largest DMA block that the sequencer launches, in bytes.
    localparam int MAX_BLOCK_BYTES = 65536;

    localparam int TIME_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int LENGTH_W   = 24;
    localparam int TICKS_W    = 8;
    localparam int BLOCK_W    = 17;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LENGTH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_WAIT_TICKS     = 3'd4;

    // Reset values of the tick registers.
    localparam logic [TICKS_W-1:0] RESET_HOLD_TICKS_INIT    = 8'd2;
    localparam logic [TICKS_W-1:0] RESET_RELEASE_TICKS_INIT = 8'd3;
    localparam logic [TICKS_W-1:0] DONE_WAIT_TICKS_INIT     = 8'd2;

    // Phase codes as they appear on the result word.
    localparam logic [PHASE_W-1:0] PHASE_CODE_INIT       = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_RESET      = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_RESET_WAIT = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_UPLOAD     = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_CODE_UPLOADED   = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_CODE_READY      = 3'd5;

    typedef enum logic [5:0] {
        PH_INIT       = 6'b000001,
        PH_RESET      = 6'b000010,
        PH_RESET_WAIT = 6'b000100,
        PH_UPLOAD     = 6'b001000,
        PH_UPLOADED   = 6'b010000,
        PH_READY      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic              dma_block_done;
        logic              done_level;
    } poll_t;

    typedef struct packed {
        logic               progressed;
        logic [PHASE_W-1:0] phase;
        logic               chip_select_level;
        logic               reset_level;
        logic               dma_start;
        logic [ADDR_W-1:0]  dma_address;
        logic [BLOCK_W-1:0] dma_block_length;
        logic               ready_res;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   image_base_address;
        logic [LENGTH_W-1:0] image_length;
        logic [TICKS_W-1:0]  reset_hold_ticks;
        logic [TICKS_W-1:0]  reset_release_ticks;
        logic [TICKS_W-1:0]  done_wait_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   deadline;
        logic [LENGTH_W-1:0] bytes_left;
        logic [LENGTH_W-1:0] bytes_sent;
        logic [BLOCK_W-1:0]  block_bytes;
        logic                select_pin;
        logic                reset_pin;
        logic [ADDR_W-1:0]   latched_base;
    } seq_state_t;

    // Limits a remaining byte count to one DMA block.
    function automatic logic [BLOCK_W-1:0] clip_block(input logic [LENGTH_W-1:0] n);
        logic [BLOCK_W-1:0] r;
        if (n > LENGTH_W'(MAX_BLOCK_BYTES))
            r = BLOCK_W'(MAX_BLOCK_BYTES);
        else
            r = n[BLOCK_W-1:0];
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        case (p)
            PH_INIT:       c = PHASE_CODE_INIT;
            PH_RESET:      c = PHASE_CODE_RESET;
            PH_RESET_WAIT: c = PHASE_CODE_RESET_WAIT;
            PH_UPLOAD:     c = PHASE_CODE_UPLOAD;
            PH_UPLOADED:   c = PHASE_CODE_UPLOADED;
            PH_READY:      c = PHASE_CODE_READY;
            default:       c = PHASE_CODE_INIT;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/fcl_stream_if.sv
`timescale 1ns / 1ps
// ============================================================================
// fcl_stream_if
// Valid/ready channel that carries one word of a given payload type.
// ============================================================================
interface fcl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/fcl_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// fcl_cfg_regs
// Configuration register file written through a plain write port.
// ============================================================================
module fcl_cfg_regs
    import fcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_base_address  <= '0;
            cfg_reg.image_length        <= '0;
            cfg_reg.reset_hold_ticks    <= RESET_HOLD_TICKS_INIT;
            cfg_reg.reset_release_ticks <= RESET_RELEASE_TICKS_INIT;
            cfg_reg.done_wait_ticks     <= DONE_WAIT_TICKS_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_BASE_ADDRESS:  cfg_reg.image_base_address  <= cfg_data[ADDR_W-1:0];
                REG_IMAGE_LENGTH:        cfg_reg.image_length        <= cfg_data[LENGTH_W-1:0];
                REG_RESET_HOLD_TICKS:    cfg_reg.reset_hold_ticks    <= cfg_data[TICKS_W-1:0];
                REG_RESET_RELEASE_TICKS: cfg_reg.reset_release_ticks <= cfg_data[TICKS_W-1:0];
                REG_DONE_WAIT_TICKS:     cfg_reg.done_wait_ticks     <= cfg_data[TICKS_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/fcl_step.sv
`timescale 1ns / 1ps
// ============================================================================
// fcl_step
// Next-state and result logic for one poll of the load sequencer.
// ============================================================================
module fcl_step
    import fcl_pkg::*;
(
    input  cfg_t       cfg,
    input  seq_state_t cur,
    input  poll_t      poll,
    output seq_state_t nxt,
    output result_t    res
);

    logic                expired;
    logic                finished;
    logic [LENGTH_W-1:0] left_after;
    logic [LENGTH_W-1:0] sent_after;
    logic [BLOCK_W-1:0]  clip_after;
    logic [LENGTH_W-1:0] clip_first;

    // A wait ends once the deadline is not after the current time.
    assign expired    = !(cur.deadline > poll.time_now);
    assign left_after = cur.bytes_left - LENGTH_W'(cur.block_bytes);
    assign sent_after = cur.bytes_sent + LENGTH_W'(cur.block_bytes);
    assign clip_after = clip_block(left_after);
    assign clip_first = cfg.image_length;

    always_comb
    begin
        nxt                  = cur;
        res                  = '0;
        finished             = 1'b0;

        case (cur.phase)
            PH_READY:
            begin
            end
            PH_INIT:
            begin
                nxt.deadline   = poll.time_now + TIME_W'(cfg.reset_hold_ticks);
                nxt.phase      = PH_RESET;
                nxt.select_pin = 1'b0;
                nxt.reset_pin  = 1'b0;
                res.progressed = 1'b1;
            end
            PH_RESET:
            begin
                if (expired)
                begin
                    nxt.phase      = PH_RESET_WAIT;
                    nxt.deadline   = poll.time_now + TIME_W'(cfg.reset_release_ticks);
                    nxt.reset_pin  = 1'b1;
                    res.progressed = 1'b1;
                end
            end
            PH_RESET_WAIT:
            begin
                if (expired)
                begin
                    nxt.phase            = PH_UPLOAD;
                    nxt.latched_base     = cfg.image_base_address;
                    nxt.bytes_left       = clip_first;
                    nxt.bytes_sent       = '0;
                    nxt.block_bytes      = clip_block(clip_first);
                    res.dma_start        = 1'b1;
                    res.dma_address      = cfg.image_base_address;
                    res.dma_block_length = clip_block(clip_first);
                    res.progressed       = 1'b1;
                end
            end
            PH_UPLOAD:
            begin
                if (cur.bytes_left == '0)
                begin
                    finished = 1'b1;
                end
                else if (poll.dma_block_done)
                begin
                    nxt.bytes_left = left_after;
                    nxt.bytes_sent = sent_after;
                    if (left_after == '0)
                    begin
                        finished = 1'b1;
                    end
                    else
                    begin
                        // A follow-on block does not count as progress.
                        nxt.block_bytes      = clip_after;
                        res.dma_start        = 1'b1;
                        res.dma_address      = cur.latched_base + ADDR_W'(sent_after);
                        res.dma_block_length = clip_after;
                    end
                end
                if (finished)
                begin
                    nxt.phase      = PH_UPLOADED;
                    nxt.select_pin = 1'b1;
                    nxt.deadline   = poll.time_now + TIME_W'(cfg.done_wait_ticks);
                    res.progressed = 1'b1;
                end
            end
            PH_UPLOADED:
            begin
                if (expired)
                begin
                    nxt.phase      = poll.done_level ? PH_READY : PH_INIT;
                    res.progressed = 1'b1;
                end
            end
            default:
            begin
                nxt.phase      = PH_INIT;
                res.progressed = 1'b1;
            end
        endcase

        res.phase             = phase_code(nxt.phase);
        res.chip_select_level = nxt.select_pin;
        res.reset_level       = nxt.reset_pin;
        res.ready_res         = (nxt.phase == PH_READY);
    end

endmodule

FILE: hdl/fpga_config_load_sequencer.sv
`timescale 1ns / 1ps
// ============================================================================
// fpga_config_load_sequencer
// Sequencer that resets a slave FPGA, streams its configuration image in DMA
// blocks and checks the DONE pin, one poll word at a time.
// ============================================================================
//
//  Channel   Direction  Payload   Handshake
//  --------  ---------  --------  -------------------------------------------
//  poll      in         poll_t    poll.valid / poll.ready
//  result    out        result_t  result.valid / result.ready
//  cfg_*     in         32 bits   cfg_we, no wait, no read-back
//
//  Each poll word passes from acceptance to result through the input register,
//  where the sequencer state is read and updated, and then through the result
//  register. One word is accepted every cycle as long as the result side
//  keeps taking words; the sequencer state is the only loop. When the result
//  register is full and not taken, the input register holds its word and
//  poll.ready falls once both are full. After reset the phase is init with
//  the FPGA reset pin released, and no clearing pass is needed.
//
module fpga_config_load_sequencer
    import fcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fcl_stream_if.sink            poll,
    fcl_stream_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    step_res;

    // Input stage: holds one accepted poll word.
    logic       in_valid_reg;
    poll_t      in_word_reg;

    // Result stage: holds one finished result word.
    logic       out_valid_reg;
    result_t    out_word_reg;

    logic       out_free;
    logic       advance;
    logic       in_fire;

    fcl_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcl_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .poll (in_word_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // The result register can take a word when it is empty or being drained.
    // The word in the input register moves on, and commits its state update,
    // exactly when that happens.
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign poll.ready = !in_valid_reg || out_free;
    assign in_fire    = poll.valid && poll.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg <= poll.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_INIT;
            state_reg.deadline     <= '0;
            state_reg.bytes_left   <= '0;
            state_reg.bytes_sent   <= '0;
            state_reg.block_bytes  <= '0;
            state_reg.select_pin   <= 1'b0;
            state_reg.reset_pin    <= 1'b1;
            state_reg.latched_base <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= step_res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

endmodule

FILE: hdl/fcl_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fcl_checker
// Port-level checks on the result words of the load sequencer.
// ============================================================================
module fcl_checker
    import fcl_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res_payload
);

    // A stalled result word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result word changed while stalled");

    // Ready is reported exactly in the ready phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_payload.ready_res == (res_payload.phase == PHASE_CODE_READY)))
        else $error("ready flag disagrees with phase");

    // Without a launch the block fields are zero, and a block never exceeds the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_payload.dma_start ||
                       (res_payload.dma_address == '0 && res_payload.dma_block_length == '0))
                      && (res_payload.dma_block_length <= BLOCK_W'(MAX_BLOCK_BYTES)))
        else $error("DMA block fields inconsistent");

    // The FPGA reset pin is driven low only in the reset phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_payload.reset_level == (res_payload.phase != PHASE_CODE_RESET)))
        else $error("reset pin level disagrees with phase");

endmodule

bind fpga_config_load_sequencer fcl_checker u_fcl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_payload (result.payload)
);
